// ===== rtl/meter_pulse_detector_assert.svh =====
// Assertion macros shared by the detector RTL.
`ifndef METER_PULSE_DETECTOR_ASSERT_SVH
`define METER_PULSE_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
package mpd_pkg;

    localparam int WEIGHT_BITS  = 9;
    localparam int WEIGHT_SHIFT = 8;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 9'd256;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int LEN_BITS       = 8;
    localparam int COUNT_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_MARGIN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PULSE_LEN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PULSE_LEN = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MS     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_WEIGHT   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FALL_WEIGHT   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_WEIGHT   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SNR_WEIGHT    = 3'd7;

    localparam logic [7:0]               RST_LEVEL_MARGIN  = 8'd15;
    localparam logic [LEN_BITS-1:0]      RST_MIN_PULSE_LEN = 8'd3;
    localparam logic [LEN_BITS-1:0]      RST_MAX_PULSE_LEN = 8'd15;
    localparam logic [CFG_DATA_BITS-1:0] RST_WINDOW_MS     = 32'd60000;
    localparam logic [WEIGHT_BITS-1:0]   RST_RISE_WEIGHT   = 9'd240;
    localparam logic [WEIGHT_BITS-1:0]   RST_FALL_WEIGHT   = 9'd252;
    localparam logic [WEIGHT_BITS-1:0]   RST_PEAK_WEIGHT   = 9'd240;
    localparam logic [WEIGHT_BITS-1:0]   RST_SNR_WEIGHT    = 9'd240;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2,
        EV_CLOSE  = 2'd3
    } t_event;

endpackage

// ===== rtl/mpd_blend.sv =====
module mpd_blend #(
    parameter int W = 19
) (
    input  logic signed [W-1:0]                   i_old,
    input  logic signed [W-1:0]                   i_new,
    input  logic        [mpd_pkg::WEIGHT_BITS-1:0] i_weight,
    output logic signed [W-1:0]                   o_avg
);
    import mpd_pkg::*;

    localparam int SUM_BITS = W + WEIGHT_BITS + 2;

    logic        [WEIGHT_BITS-1:0] w_old;
    logic        [WEIGHT_BITS-1:0] w_new;
    logic signed [SUM_BITS-1:0]    p_old;
    logic signed [SUM_BITS-1:0]    p_new;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SUM_BITS-1:0]    sum_adj;
    logic signed [SUM_BITS-1:0]    quot;

    // The weighted sum is divided by 256 with truncation toward zero.
    always_comb begin
        w_old   = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
        w_new   = WEIGHT_ONE - w_old;
        p_old   = SUM_BITS'(i_old) * SUM_BITS'($signed({1'b0, w_old}));
        p_new   = SUM_BITS'(i_new) * SUM_BITS'($signed({1'b0, w_new}));
        sum     = p_old + p_new;
        sum_adj = sum[SUM_BITS-1] ? sum + SUM_BITS'(WEIGHT_ONE - 9'd1) : sum;
        quot    = sum_adj >>> WEIGHT_SHIFT;
        o_avg   = quot[W-1:0];
    end

endmodule

// ===== rtl/meter_pulse_detector.sv =====
// Optical meter pulse detector.
// Input channel (i_in_valid / o_in_ready) carries one sensor sample and the
// current millisecond tick per transfer. Output channel (o_out_valid /
// i_out_ready) returns exactly one result per input transfer, in order.
// Each sample passes through an input register, one stage of logic that
// updates the baseline, pulse-level and SNR averages and the pulse and
// window counters, and a result register. One item is taken per cycle when
// the receiver keeps up; the averages feed back through their weighted
// multiply into their own registers, and that recurrence sets the rate.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more sample; then o_in_ready drops
// until the result is transferred.
// The configuration port writes one register per cycle with i_cfg_wr_en
// and should only be used while no sample is in flight.
// Synchronous reset restores the default configuration, empties all three
// averages, clears the counters and drops both valid flags.
module meter_pulse_detector #(
    parameter int SAMPLE_BITS   = 8,
    parameter int FRACTION_BITS = 10,
    parameter int TICK_BITS     = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [mpd_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [mpd_pkg::CFG_DATA_BITS-1:0]     i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                i_sample,
    input  logic [TICK_BITS-1:0]                  i_tick_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_pulse_present,
    output mpd_pkg::t_event                       o_event_res,
    output logic [mpd_pkg::LEN_BITS-1:0]          o_pulse_len,
    output logic [TICK_BITS-1:0]                  o_pulse_ms,
    output logic [mpd_pkg::COUNT_BITS-1:0]        o_total_pulses,
    output logic [mpd_pkg::COUNT_BITS-1:0]        o_window_pulses,
    output logic [TICK_BITS-1:0]                  o_window_elapsed,
    output logic [SAMPLE_BITS-1:0]                o_baseline_level,
    output logic [SAMPLE_BITS-1:0]                o_peak_level,
    output logic signed [SAMPLE_BITS:0]           o_snr_level
);
    import mpd_pkg::*;

    localparam int AVG_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int SNR_BITS = AVG_BITS + 1;
    localparam int CMP_BITS = CFG_DATA_BITS + 1;

    // Configuration.
    logic [7:0]               r_margin;
    logic [LEN_BITS-1:0]      r_min_len;
    logic [LEN_BITS-1:0]      r_max_len;
    logic [CFG_DATA_BITS-1:0] r_window_ms;
    logic [WEIGHT_BITS-1:0]   r_rise_w;
    logic [WEIGHT_BITS-1:0]   r_fall_w;
    logic [WEIGHT_BITS-1:0]   r_peak_w;
    logic [WEIGHT_BITS-1:0]   r_snr_w;

    // Input register.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic [TICK_BITS-1:0]   r_in_tick;

    // Detector state.
    logic [AVG_BITS-1:0]        r_base_avg, n_base_avg;
    logic [AVG_BITS-1:0]        r_peak_avg, n_peak_avg;
    logic signed [SNR_BITS-1:0] r_snr_avg,  n_snr_avg;
    logic                       r_prev_present;
    logic                       r_counting, n_counting;
    logic [LEN_BITS-1:0]        r_len, n_len;
    logic [TICK_BITS-1:0]       r_rise_tick, n_rise_tick;
    logic [COUNT_BITS-1:0]      r_total, n_total;
    logic [TICK_BITS-1:0]       r_win_tick, n_win_tick;
    logic [COUNT_BITS-1:0]      r_win_count, n_win_count;

    // Result register.
    logic                       r_out_valid;
    logic                       r_present, n_present;
    t_event                     r_event, n_event;
    logic [LEN_BITS-1:0]        r_plen, n_plen;
    logic [TICK_BITS-1:0]       r_pms, n_pms;
    logic [COUNT_BITS-1:0]      r_wp, n_wp;
    logic [TICK_BITS-1:0]       r_we, n_we;

    logic                       advance;
    logic [AVG_BITS-1:0]        sfix;
    logic [WEIGHT_BITS-1:0]     base_w;
    logic signed [SNR_BITS-1:0] base_blend;
    logic signed [SNR_BITS-1:0] peak_blend;
    logic signed [SNR_BITS-1:0] snr_blend;
    logic signed [SAMPLE_BITS:0] snr_cur;
    logic signed [SNR_BITS-1:0] snr_fix;
    logic [SAMPLE_BITS:0]       level_sum;
    logic [LEN_BITS-1:0]        len_inc;
    logic                       rise, fall, len_ok, pulse_ok, win_close;
    logic [TICK_BITS-1:0]       win_tick_eff;
    logic [COUNT_BITS-1:0]      win_count_eff;
    logic [TICK_BITS-1:0]       win_delta;
    logic [CFG_DATA_BITS-1:0]   win_len;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign sfix   = {r_in_sample, {FRACTION_BITS{1'b0}}};
    assign base_w = (r_in_sample > r_base_avg[AVG_BITS-1:FRACTION_BITS]) ? r_rise_w : r_fall_w;

    assign snr_cur = $signed({1'b0, r_in_sample})
                   - $signed({1'b0, r_peak_avg[AVG_BITS-1:FRACTION_BITS]});
    assign snr_fix = {snr_cur, {FRACTION_BITS{1'b0}}};

    mpd_blend #(.W(SNR_BITS)) u_base_blend (
        .i_old    ($signed({1'b0, r_base_avg})),
        .i_new    ($signed({1'b0, sfix})),
        .i_weight (base_w),
        .o_avg    (base_blend)
    );

    mpd_blend #(.W(SNR_BITS)) u_peak_blend (
        .i_old    ($signed({1'b0, r_peak_avg})),
        .i_new    ($signed({1'b0, sfix})),
        .i_weight (r_peak_w),
        .o_avg    (peak_blend)
    );

    mpd_blend #(.W(SNR_BITS)) u_snr_blend (
        .i_old    (r_snr_avg),
        .i_new    (snr_fix),
        .i_weight (r_snr_w),
        .o_avg    (snr_blend)
    );

    always_comb begin
        n_base_avg = (r_base_avg == '0) ? sfix : base_blend[AVG_BITS-1:0];
        level_sum  = {1'b0, r_in_sample} + (SAMPLE_BITS+1)'(r_margin);
        n_present  = {1'b0, n_base_avg[AVG_BITS-1:FRACTION_BITS]} > level_sum;

        n_peak_avg = r_peak_avg;
        if (n_present) begin
            n_peak_avg = (r_peak_avg == '0) ? sfix : peak_blend[AVG_BITS-1:0];
        end

        n_snr_avg = r_snr_avg;
        if (!n_present && r_peak_avg != '0) begin
            n_snr_avg = (r_snr_avg == '0) ? snr_fix : snr_blend;
        end

        rise    = n_present && !r_prev_present;
        fall    = !n_present && r_prev_present;
        len_inc = (r_counting && r_len != '1) ? r_len + LEN_BITS'(1) : r_len;

        n_len       = rise ? '0 : len_inc;
        n_counting  = rise ? 1'b1 : (fall ? 1'b0 : r_counting);
        n_rise_tick = rise ? r_in_tick : r_rise_tick;

        len_ok   = (len_inc >= r_min_len) && (len_inc < r_max_len);
        pulse_ok = fall && len_ok;
        n_total  = pulse_ok ? r_total + COUNT_BITS'(1) : r_total;

        // The first accepted pulse with a nonzero tick opens the window.
        win_tick_eff  = (pulse_ok && r_win_tick == '0) ? r_in_tick : r_win_tick;
        win_count_eff = (pulse_ok && r_win_tick == '0) ? n_total : r_win_count;
        win_delta     = r_in_tick - win_tick_eff;
        win_len       = (r_window_ms == '0) ? CFG_DATA_BITS'(1) : r_window_ms;
        win_close     = pulse_ok && (CMP_BITS'(win_delta) >= CMP_BITS'(win_len));

        n_win_tick  = win_close ? r_in_tick : win_tick_eff;
        n_win_count = win_close ? n_total : win_count_eff;

        n_wp = win_close ? n_total - COUNT_BITS'(1) - win_count_eff : '0;
        n_we = win_close ? win_delta : '0;

        n_plen = fall ? len_inc : '0;
        n_pms  = fall ? r_in_tick - r_rise_tick : '0;

        priority if (win_close) begin
            n_event = EV_CLOSE;
        end else if (pulse_ok) begin
            n_event = EV_ACCEPT;
        end else if (fall) begin
            n_event = EV_REJECT;
        end else begin
            n_event = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin    <= RST_LEVEL_MARGIN;
            r_min_len   <= RST_MIN_PULSE_LEN;
            r_max_len   <= RST_MAX_PULSE_LEN;
            r_window_ms <= RST_WINDOW_MS;
            r_rise_w    <= RST_RISE_WEIGHT;
            r_fall_w    <= RST_FALL_WEIGHT;
            r_peak_w    <= RST_PEAK_WEIGHT;
            r_snr_w     <= RST_SNR_WEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LEVEL_MARGIN:  r_margin    <= i_cfg_wdata[7:0];
                CFG_MIN_PULSE_LEN: r_min_len   <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_MAX_PULSE_LEN: r_max_len   <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_WINDOW_MS:     r_window_ms <= i_cfg_wdata;
                CFG_RISE_WEIGHT:   r_rise_w    <= i_cfg_wdata[WEIGHT_BITS-1:0];
                CFG_FALL_WEIGHT:   r_fall_w    <= i_cfg_wdata[WEIGHT_BITS-1:0];
                CFG_PEAK_WEIGHT:   r_peak_w    <= i_cfg_wdata[WEIGHT_BITS-1:0];
                CFG_SNR_WEIGHT:    r_snr_w     <= i_cfg_wdata[WEIGHT_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_sample <= i_sample;
            r_in_tick   <= i_tick_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_avg     <= '0;
            r_peak_avg     <= '0;
            r_snr_avg      <= '0;
            r_prev_present <= 1'b0;
            r_counting     <= 1'b0;
            r_len          <= '0;
            r_rise_tick    <= '0;
            r_total        <= '0;
            r_win_tick     <= '0;
            r_win_count    <= '0;
        end else if (advance) begin
            r_base_avg     <= n_base_avg;
            r_peak_avg     <= n_peak_avg;
            r_snr_avg      <= n_snr_avg;
            r_prev_present <= n_present;
            r_counting     <= n_counting;
            r_len          <= n_len;
            r_rise_tick    <= n_rise_tick;
            r_total        <= n_total;
            r_win_tick     <= n_win_tick;
            r_win_count    <= n_win_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_present <= n_present;
            r_event   <= n_event;
            r_plen    <= n_plen;
            r_pms     <= n_pms;
            r_wp      <= n_wp;
            r_we      <= n_we;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pulse_present  = r_present;
    assign o_event_res      = r_event;
    assign o_pulse_len      = r_plen;
    assign o_pulse_ms       = r_pms;
    assign o_total_pulses   = r_total;
    assign o_window_pulses  = r_wp;
    assign o_window_elapsed = r_we;
    assign o_baseline_level = r_base_avg[AVG_BITS-1:FRACTION_BITS];
    assign o_peak_level     = r_peak_avg[AVG_BITS-1:FRACTION_BITS];
    assign o_snr_level      = r_snr_avg[SNR_BITS-1:FRACTION_BITS];

`include "meter_pulse_detector_assert.svh"

    `MPD_ASSERT_IMP(a_event_only_at_end, o_out_valid && o_event_res != EV_NONE, !o_pulse_present, "pulse event reported while a pulse is still present")
    `MPD_ASSERT_IMP(a_quiet_no_length, o_out_valid && o_event_res == EV_NONE, o_pulse_len == '0 && o_pulse_ms == '0, "pulse length reported without an event")
    `MPD_ASSERT_IMP(a_window_only_on_close, o_out_valid && o_event_res != EV_CLOSE, o_window_pulses == '0 && o_window_elapsed == '0, "window figures reported without a closed window")
    `MPD_ASSERT_IMP(a_counting_tracks_pulse, 1'b1, r_counting == r_prev_present, "length counter out of step with pulse state")
    `MPD_ASSERT_NXT(a_free_stage_moves, r_in_valid && !r_out_valid, r_out_valid, "held sample did not move into a free result register")

endmodule
